FILE: src/aso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_pkg - shared types for the ARM shifter operand unit
// Beat structs for both channels, shift type codes and the decoded
// control word that drives the rotate and mask datapath.
// ----------------------------------------------------------------------------
package aso_pkg;

  localparam int WORD_W = 32;
  localparam int AMT_W  = 5;

  // Shift type codes as encoded in the instruction
  typedef enum logic [1:0] {
    FUNC_LSL = 2'd0,
    FUNC_LSR = 2'd1,
    FUNC_ASR = 2'd2,
    FUNC_ROR = 2'd3
  } shift_func_t;

  // Which bits of the rotated word survive; the rest take the fill bit
  typedef enum logic [1:0] {
    MASK_ALL  = 2'd0,
    MASK_NONE = 2'd1,
    MASK_LOW  = 2'd2,   // ones >> n
    MASK_HIGH = 2'd3    // ones << n
  } mask_kind_t;

  // Source of the shifter carry out
  typedef enum logic [1:0] {
    CARRY_CIN  = 2'd0,
    CARRY_ZERO = 2'd1,
    CARRY_BIT  = 2'd2
  } carry_kind_t;

  typedef struct packed {
    logic [1:0]        func;
    logic              by_register;
    logic [WORD_W-1:0] rm_value;
    logic [7:0]        rs_amount;
    logic [AMT_W-1:0]  imm_amount;
    logic              carry_in;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] operand;
    logic              carry_out;
  } out_beat_t;

  // Decoded control: every form reduces to rotate, mask, fill, carry pick
  typedef struct packed {
    logic [AMT_W-1:0] rot;
    mask_kind_t       mask_kind;
    logic [AMT_W-1:0] mask_n;
    logic             fill;
    carry_kind_t      carry_kind;
    logic [AMT_W-1:0] carry_idx;
  } ctrl_t;

endpackage

FILE: src/aso_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_decode - shift form decoder
// Maps shift type, amount source and amount onto one rotate amount, a
// keep mask, a fill bit and a carry source.
// ----------------------------------------------------------------------------
module aso_decode
  import aso_pkg::*;
(
  input  in_beat_t op,
  output ctrl_t    ctrl
);

  logic             sign;
  logic [AMT_W-1:0] rs_lo;
  logic             rs_small;
  logic             rs_32;

  assign sign     = op.rm_value[WORD_W-1];
  assign rs_lo    = op.rs_amount[AMT_W-1:0];
  assign rs_small = (op.rs_amount[7:AMT_W] == 3'd0);
  assign rs_32    = (op.rs_amount == 8'd32);

  always_comb begin
    // pass-through: Rm unchanged, carry keeps C
    ctrl.rot        = '0;
    ctrl.mask_kind  = MASK_ALL;
    ctrl.mask_n     = '0;
    ctrl.fill       = 1'b0;
    ctrl.carry_kind = CARRY_CIN;
    ctrl.carry_idx  = '0;

    if (op.by_register) begin
      if (op.rs_amount != 8'd0) begin
        case (shift_func_t'(op.func))
          FUNC_LSL: begin
            if (rs_small) begin
              ctrl.rot        = AMT_W'(0) - rs_lo;
              ctrl.mask_kind  = MASK_HIGH;
              ctrl.mask_n     = rs_lo;
              ctrl.carry_kind = CARRY_BIT;
              ctrl.carry_idx  = AMT_W'(0) - rs_lo;
            end else if (rs_32) begin
              ctrl.mask_kind  = MASK_NONE;
              ctrl.carry_kind = CARRY_BIT;
              ctrl.carry_idx  = '0;
            end else begin
              ctrl.mask_kind  = MASK_NONE;
              ctrl.carry_kind = CARRY_ZERO;
            end
          end
          FUNC_LSR, FUNC_ASR: begin
            ctrl.fill = (op.func == FUNC_ASR) ? sign : 1'b0;
            if (rs_small) begin
              ctrl.rot        = rs_lo;
              ctrl.mask_kind  = MASK_LOW;
              ctrl.mask_n     = rs_lo;
              ctrl.carry_kind = CARRY_BIT;
              ctrl.carry_idx  = rs_lo - AMT_W'(1);
            end else if (rs_32 || op.func == FUNC_ASR) begin
              ctrl.mask_kind  = MASK_NONE;
              ctrl.carry_kind = CARRY_BIT;
              ctrl.carry_idx  = AMT_W'(WORD_W - 1);
            end else begin
              ctrl.mask_kind  = MASK_NONE;
              ctrl.carry_kind = CARRY_ZERO;
            end
          end
          FUNC_ROR: begin
            ctrl.rot        = rs_lo;
            ctrl.carry_kind = CARRY_BIT;
            // multiple of 32: word unchanged, carry from bit 31
            ctrl.carry_idx  = rs_lo - AMT_W'(1);
          end
          default: begin
            ctrl.mask_kind = MASK_ALL;
          end
        endcase
      end
    end else begin
      case (shift_func_t'(op.func))
        FUNC_LSL: begin
          if (op.imm_amount != '0) begin
            ctrl.rot        = AMT_W'(0) - op.imm_amount;
            ctrl.mask_kind  = MASK_HIGH;
            ctrl.mask_n     = op.imm_amount;
            ctrl.carry_kind = CARRY_BIT;
            ctrl.carry_idx  = AMT_W'(0) - op.imm_amount;
          end
        end
        FUNC_LSR, FUNC_ASR: begin
          ctrl.fill       = (op.func == FUNC_ASR) ? sign : 1'b0;
          ctrl.carry_kind = CARRY_BIT;
          if (op.imm_amount == '0) begin
            // amount zero encodes a shift by 32
            ctrl.mask_kind = MASK_NONE;
            ctrl.carry_idx = AMT_W'(WORD_W - 1);
          end else begin
            ctrl.rot       = op.imm_amount;
            ctrl.mask_kind = MASK_LOW;
            ctrl.mask_n    = op.imm_amount;
            ctrl.carry_idx = op.imm_amount - AMT_W'(1);
          end
        end
        FUNC_ROR: begin
          ctrl.carry_kind = CARRY_BIT;
          if (op.imm_amount == '0) begin
            // RRX: rotate by one, top bit from C
            ctrl.rot       = AMT_W'(1);
            ctrl.mask_kind = MASK_LOW;
            ctrl.mask_n    = AMT_W'(1);
            ctrl.fill      = op.carry_in;
            ctrl.carry_idx = '0;
          end else begin
            ctrl.rot       = op.imm_amount;
            ctrl.carry_idx = op.imm_amount - AMT_W'(1);
          end
        end
        default: begin
          ctrl.mask_kind = MASK_ALL;
        end
      endcase
    end
  end

endmodule

FILE: src/arm_shifter_operand_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_shifter_operand_unit - ARM data-processing shifter operand
// Barrel shifter with carry out for LSL, LSR, ASR, ROR and RRX, register
// or immediate amount, as a four-stage pipeline.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------
//   op      | in  | op_valid / op_stall  | in_beat_t  (Rm, amount, C)
//   res     | out | res_valid / res_stall| out_beat_t (operand, carry)
//
// res_valid rises once an accepted beat has passed the decode, coarse rotate,
// fine rotate and output registers; one beat per cycle is taken
// as long as res_stall is low. Stages: decode, coarse rotate with mask build,
// fine rotate, mask and fill into the output register.
// Reset clears the stage valid bits only. A stall holds each occupied stage;
// empty stages still fill, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module arm_shifter_operand_unit
  import aso_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_stall,
  input  in_beat_t  op,
  output logic      res_valid,
  input  logic      res_stall,
  output out_beat_t res
);

  // rotate right of one word
  function automatic logic [WORD_W-1:0] ror_word(input logic [WORD_W-1:0] x,
                                                 input logic [AMT_W-1:0]  n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

  ctrl_t ctrl;

  aso_decode u_decode (
    .op   (op),
    .ctrl (ctrl)
  );

  // stage valid bits and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || !res_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign op_stall  = !en1;
  assign res_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= op_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: decoded control and operand
  ctrl_t             s1_ctrl;
  logic [WORD_W-1:0] s1_rm;
  logic              s1_cin;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctrl <= ctrl;
      s1_rm   <= op.rm_value;
      s1_cin  <= op.carry_in;
    end
  end

  // stage 2: rotate by multiples of eight, build mask, pick carry
  logic [WORD_W-1:0] s2_word_next, s2_mask_next;
  logic              s2_carry_next;
  logic [WORD_W-1:0] s2_word, s2_mask;
  logic [2:0]        s2_rot;
  logic              s2_fill, s2_carry;

  always_comb begin
    s2_word_next = ror_word(s1_rm, {s1_ctrl.rot[AMT_W-1:3], 3'b000});
    case (s1_ctrl.mask_kind)
      MASK_ALL:  s2_mask_next = '1;
      MASK_NONE: s2_mask_next = '0;
      MASK_LOW:  s2_mask_next = {WORD_W{1'b1}} >> s1_ctrl.mask_n;
      MASK_HIGH: s2_mask_next = {WORD_W{1'b1}} << s1_ctrl.mask_n;
      default:   s2_mask_next = '1;
    endcase
    case (s1_ctrl.carry_kind)
      CARRY_CIN:  s2_carry_next = s1_cin;
      CARRY_ZERO: s2_carry_next = 1'b0;
      CARRY_BIT:  s2_carry_next = s1_rm[s1_ctrl.carry_idx];
      default:    s2_carry_next = s1_cin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_word  <= s2_word_next;
      s2_mask  <= s2_mask_next;
      s2_rot   <= s1_ctrl.rot[2:0];
      s2_fill  <= s1_ctrl.fill;
      s2_carry <= s2_carry_next;
    end
  end

  // stage 3: rotate by the remaining zero to seven bits
  logic [WORD_W-1:0] s3_word, s3_mask;
  logic              s3_fill, s3_carry;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_word  <= ror_word(s2_word, {2'b00, s2_rot});
      s3_mask  <= s2_mask;
      s3_fill  <= s2_fill;
      s3_carry <= s2_carry;
    end
  end

  // stage 4: keep masked bits, fill the rest, into the output register
  always_ff @(posedge clk) begin
    if (en4) begin
      res.operand   <= (s3_word & s3_mask) | ({WORD_W{s3_fill}} & ~s3_mask);
      res.carry_out <= s3_carry;
    end
  end

endmodule

FILE: src/aso_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_checker - port-level checks for the shifter operand unit
// Output hold under stall, pipeline flow and a pass-through spot check.
// ----------------------------------------------------------------------------
module aso_checker
  import aso_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      op_valid,
  input logic      op_stall,
  input in_beat_t  op,
  input logic      res_valid,
  input logic      res_stall,
  input out_beat_t res
);

  logic op_beat;
  assign op_beat = op_valid && !op_stall;

  // a stalled result beat stays and holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat dropped or changed under stall");

  // no backpressure on the input unless the output is stalled
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !res_stall |-> !op_stall)
    else $error("input stalled while output flows");

  // an accepted beat is offered at the output when nothing stalls in between
  a_latency: assert property (@(posedge clk) disable iff (rst)
    op_beat ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid)
    else $error("result missing after pipeline latency");

  // zero register amount passes Rm and C straight through
  a_pass: assert property (@(posedge clk) disable iff (rst)
    (op_beat && op.by_register && op.rs_amount == 8'd0)
      ##1 !res_stall ##1 !res_stall ##1 !res_stall
    |=> res.operand == $past(op.rm_value, 4) && res.carry_out == $past(op.carry_in, 4))
    else $error("zero-amount register shift altered the operand");

endmodule

bind arm_shifter_operand_unit aso_checker u_aso_checker (.*);

FILE: verif/arm_shifter_operand_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_shifter_operand_unit_tb - self-checking bench for the shifter operand
// A short table of directed beats covers the shift extremes, register
// amounts of zero, 32 and over 32, the immediate zero forms and RRX.
// Random beats follow, with idle cycles on both channels. Every result
// beat is checked in order against a typed-in or locally calculated result.
// ----------------------------------------------------------------------------
module arm_shifter_operand_unit_tb;
  import aso_pkg::*;

  localparam int RAND_BEATS  = 1525;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 12;
  localparam int MAX_REPORTS = 10;

  // One directed beat; known rows carry their result typed in
  typedef struct packed {
    shift_func_t func;
    logic        by_reg;
    logic [31:0] rm;
    logic [7:0]  rs;
    logic [4:0]  imm;
    logic        cin;
    logic        known;
    logic [31:0] want_op;
    logic        want_c;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      op_valid = 1'b0;
  logic      op_stall;
  in_beat_t  op = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_beat_t res;

  logic      quiet = 1'b0;
  out_beat_t operand_q[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;

  arm_shifter_operand_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Arithmetic shift right, n in 1..31
  function automatic logic [31:0] asr_by(logic [31:0] x, int unsigned n);
    logic signed [31:0] sx;
    sx = x;
    return sx >>> n;
  endfunction

  // Rotate right, n in 1..31
  function automatic logic [31:0] ror_by(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Shifted operand and shifter carry for one beat
  function automatic out_beat_t shift_operand(in_beat_t b);
    shift_func_t kind;
    logic [31:0] rm;
    logic        sign;
    int unsigned n;
    out_beat_t   o;
    kind = shift_func_t'(b.func);
    rm   = b.rm_value;
    sign = rm[31];
    o.operand   = rm;
    o.carry_out = b.carry_in;
    if (b.by_register) begin
      n = b.rs_amount;
      // zero register amount passes Rm and C through for every type
      if (n != 0) begin
        case (kind)
          FUNC_LSL: begin
            if (n < 32) begin
              o.operand = rm << n;  o.carry_out = rm[32 - n];
            end else if (n == 32) begin
              o.operand = '0;  o.carry_out = rm[0];
            end else begin
              o.operand = '0;  o.carry_out = 1'b0;
            end
          end
          FUNC_LSR: begin
            if (n < 32) begin
              o.operand = rm >> n;  o.carry_out = rm[n - 1];
            end else if (n == 32) begin
              o.operand = '0;  o.carry_out = sign;
            end else begin
              o.operand = '0;  o.carry_out = 1'b0;
            end
          end
          FUNC_ASR: begin
            if (n < 32) begin
              o.operand = asr_by(rm, n);  o.carry_out = rm[n - 1];
            end else begin
              o.operand = {32{sign}};  o.carry_out = sign;
            end
          end
          FUNC_ROR: begin
            n = b.rs_amount[4:0];
            if (n == 0) begin
              o.operand = rm;  o.carry_out = sign;
            end else begin
              o.operand = ror_by(rm, n);  o.carry_out = rm[n - 1];
            end
          end
          default: ;
        endcase
      end
    end else begin
      n = b.imm_amount;
      case (kind)
        FUNC_LSL: begin
          if (n != 0) begin
            o.operand = rm << n;  o.carry_out = rm[32 - n];
          end
        end
        FUNC_LSR: begin
          // #0 encodes a shift by 32
          if (n == 0) begin
            o.operand = '0;  o.carry_out = sign;
          end else begin
            o.operand = rm >> n;  o.carry_out = rm[n - 1];
          end
        end
        FUNC_ASR: begin
          if (n == 0) begin
            o.operand = {32{sign}};  o.carry_out = sign;
          end else begin
            o.operand = asr_by(rm, n);  o.carry_out = rm[n - 1];
          end
        end
        FUNC_ROR: begin
          // #0 encodes RRX: C enters at the top
          if (n == 0) begin
            o.operand = {b.carry_in, rm[31:1]};  o.carry_out = rm[0];
          end else begin
            o.operand = ror_by(rm, n);  o.carry_out = rm[n - 1];
          end
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  function automatic dir_row_t mk_row(shift_func_t f, logic by_reg, logic [31:0] rm,
                                      logic [7:0] rs, logic [4:0] imm, logic cin,
                                      logic known, logic [31:0] want_op, logic want_c);
    dir_row_t r;
    r.func = f;  r.by_reg = by_reg;  r.rm = rm;  r.rs = rs;  r.imm = imm;
    r.cin = cin;  r.known = known;  r.want_op = want_op;  r.want_c = want_c;
    return r;
  endfunction

  // Random beat; register amounts lean toward 0, 32 and the multiples of 32
  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.func        = 2'($urandom_range(0, 3));
    b.by_register = 1'($urandom_range(0, 1));
    b.imm_amount  = 5'($urandom_range(0, 31));
    b.carry_in    = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       b.rs_amount = 8'd0;
      1:       b.rs_amount = 8'd32;
      2, 3, 4: b.rs_amount = 8'($urandom_range(1, 31));
      5:       b.rs_amount = 8'($urandom_range(33, 255));
      6:       b.rs_amount = 8'(32 * $urandom_range(2, 7));
      default: b.rs_amount = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 15))
      0:       b.rm_value = 32'h0000_0000;
      1:       b.rm_value = 32'hFFFF_FFFF;
      2:       b.rm_value = 32'h8000_0000;
      3:       b.rm_value = 32'h7FFF_FFFF;
      default: b.rm_value = $urandom;
    endcase
    return b;
  endfunction

  // Drive one beat and hold it until the unit takes it
  task automatic send_beat(input in_beat_t b, input out_beat_t want);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op       <= b;
    op_valid <= 1'b1;
    do @(posedge clk); while (op_stall);
    operand_q.push_back(want);
  endtask

  // Result side stalls at random outside the quiet stretch
  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (operand_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result beat: operand %h carry %b", res.operand, res.carry_out);
      end else begin
        want = operand_q.pop_front();
        if (res.operand !== want.operand || res.carry_out !== want.carry_out) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch: operand exp %h got %h, carry exp %b got %b",
                     want.operand, res.operand, want.carry_out, res.carry_out);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t  dir_table [25];
    in_beat_t  b;
    out_beat_t want;
    int        pause_at;

    // directed rows: type, by_reg, Rm, Rs, imm, C, known, operand, carry
    dir_table[0]  = mk_row(FUNC_LSL, 0, 32'h1234_5678, 8'd0,   5'd0,  1, 1, 32'h1234_5678, 1);
    dir_table[1]  = mk_row(FUNC_LSL, 0, 32'hFFFF_FFFF, 8'd0,   5'd31, 0, 1, 32'h8000_0000, 1);
    dir_table[2]  = mk_row(FUNC_LSR, 0, 32'h8000_0001, 8'd0,   5'd0,  0, 1, 32'h0000_0000, 1);
    dir_table[3]  = mk_row(FUNC_LSR, 0, 32'hFFFF_FFFF, 8'd0,   5'd31, 0, 1, 32'h0000_0001, 1);
    dir_table[4]  = mk_row(FUNC_ASR, 0, 32'h8000_0000, 8'd0,   5'd0,  0, 1, 32'hFFFF_FFFF, 1);
    dir_table[5]  = mk_row(FUNC_ASR, 0, 32'h7FFF_FFFF, 8'd0,   5'd0,  1, 1, 32'h0000_0000, 0);
    dir_table[6]  = mk_row(FUNC_ASR, 0, 32'h8000_0000, 8'd0,   5'd1,  1, 1, 32'hC000_0000, 0);
    dir_table[7]  = mk_row(FUNC_ROR, 0, 32'h0000_0003, 8'd0,   5'd0,  1, 1, 32'h8000_0001, 1);
    dir_table[8]  = mk_row(FUNC_ROR, 0, 32'hFFFF_FFFE, 8'd0,   5'd0,  0, 1, 32'h7FFF_FFFF, 0);
    dir_table[9]  = mk_row(FUNC_ROR, 0, 32'h0000_000F, 8'd0,   5'd4,  0, 1, 32'hF000_0000, 1);
    dir_table[10] = mk_row(FUNC_LSR, 1, 32'hDEAD_BEEF, 8'd0,   5'd7,  1, 1, 32'hDEAD_BEEF, 1);
    dir_table[11] = mk_row(FUNC_ROR, 1, 32'hFFFF_FFFF, 8'd0,   5'd0,  0, 1, 32'hFFFF_FFFF, 0);
    dir_table[12] = mk_row(FUNC_LSL, 1, 32'h0000_0001, 8'd32,  5'd0,  0, 1, 32'h0000_0000, 1);
    dir_table[13] = mk_row(FUNC_LSL, 1, 32'hFFFF_FFFF, 8'd33,  5'd0,  1, 1, 32'h0000_0000, 0);
    dir_table[14] = mk_row(FUNC_LSL, 1, 32'hFFFF_FFFF, 8'd255, 5'd31, 1, 1, 32'h0000_0000, 0);
    dir_table[15] = mk_row(FUNC_LSR, 1, 32'h8000_0000, 8'd32,  5'd0,  0, 1, 32'h0000_0000, 1);
    dir_table[16] = mk_row(FUNC_LSR, 1, 32'hFFFF_FFFF, 8'd33,  5'd0,  1, 1, 32'h0000_0000, 0);
    dir_table[17] = mk_row(FUNC_ASR, 1, 32'h8000_0000, 8'd32,  5'd0,  0, 1, 32'hFFFF_FFFF, 1);
    dir_table[18] = mk_row(FUNC_ASR, 1, 32'h4000_0000, 8'd255, 5'd0,  1, 1, 32'h0000_0000, 0);
    dir_table[19] = mk_row(FUNC_ROR, 1, 32'h8000_0001, 8'd32,  5'd0,  0, 1, 32'h8000_0001, 1);
    dir_table[20] = mk_row(FUNC_ROR, 1, 32'h7FFF_FFFF, 8'd64,  5'd0,  1, 1, 32'h7FFF_FFFF, 0);
    dir_table[21] = mk_row(FUNC_ROR, 1, 32'h0000_0001, 8'd33,  5'd0,  0, 1, 32'h8000_0000, 1);
    dir_table[22] = mk_row(FUNC_LSL, 1, 32'h8000_0000, 8'd1,   5'd0,  0, 1, 32'h0000_0000, 1);
    dir_table[23] = mk_row(FUNC_ASR, 1, 32'h8F00_F00F, 8'd31,  5'd17, 0, 0, '0, 0);
    dir_table[24] = mk_row(FUNC_LSR, 0, 32'hA5A5_5A5A, 8'd1,   5'd17, 1, 0, '0, 0);

    pause_at = $urandom_range(200, 500);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_table[i]) begin
      b.func        = dir_table[i].func;
      b.by_register = dir_table[i].by_reg;
      b.rm_value    = dir_table[i].rm;
      b.rs_amount   = dir_table[i].rs;
      b.imm_amount  = dir_table[i].imm;
      b.carry_in    = dir_table[i].cin;
      if (dir_table[i].known) begin
        want.operand   = dir_table[i].want_op;
        want.carry_out = dir_table[i].want_c;
      end else begin
        want = shift_operand(b);
      end
      send_beat(b, want);
    end

    // random beats; one stretch runs with no idling on either side
    for (int i = 0; i < RAND_BEATS; i++) begin
      quiet <= (i >= 700 && i < 1000);
      if (i == pause_at) begin
        // let the pipe run dry before going on
        op_valid <= 1'b0;
        while (operand_q.size() != 0) @(posedge clk);
      end
      b = rand_beat();
      send_beat(b, shift_operand(b));
    end
    op_valid <= 1'b0;

    // drain, then wait for any stray beat
    while (operand_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_cnt == 0 && operand_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
